// File: rtl/core/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and constants shared by the radix digit converter modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int RADIX_W       = 4;
	localparam int DIGIT_W       = 4;
	localparam int BITS_PER_STEP = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd8;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_WR
	} rdc_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic rd;
		logic emit;
	} rdc_cmd_t;

	typedef struct packed {
		logic step_last;
		logic div_end;
		logic idx_zero;
		logic out_free;
	} rdc_status_t;

	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

endpackage

// File: rtl/core/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: accepts a value, runs the division passes, then reads the digit
// buffer back most significant first into the output register.
// ----------------------------------------------------------------------------
module rdc_ctrl
	import rdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        busy,
	input  rdc_status_t status,
	output rdc_cmd_t    cmd
);

	rdc_state_t state_q;
	rdc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_end) state_d = ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (status.out_free) begin
					state_d = status.idx_zero ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.rd = 1'b1;
			end
			ST_EMIT_WR: begin
				cmd.emit = status.out_free;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/core/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, restoring divider (several quotient bits per cycle),
// digit buffer and output register.
// ----------------------------------------------------------------------------
module rdc_datapath
	import rdc_pkg::*;
#(
	parameter int VALUE_WIDTH = 31,
	parameter int DIGIT_SLOTS = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RADIX_W-1:0]     cfg_data,
	input  logic [VALUE_WIDTH-1:0] value,
	input  rdc_cmd_t               cmd,
	output rdc_status_t            status,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [DIGIT_W-1:0]     digit,
	output logic                   last_digit
);

	localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PW    = STEPS * BITS_PER_STEP;
	localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CW    = $clog2(DIGIT_SLOTS + 1);
	localparam int AW    = $clog2(DIGIT_SLOTS);

	logic [RADIX_W-1:0] radix_q;
	logic [PW-1:0]      work_q;
	logic [PW-1:0]      work_d;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIGIT_W-1:0] rem_d;
	logic [SCW-1:0]     step_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic [DIGIT_W-1:0] mem [DIGIT_SLOTS];
	logic [DIGIT_W-1:0] rdata_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= sat_radix(cfg_data);
		end
	end

	// bit-serial restoring division, BITS_PER_STEP quotient bits per cycle
	always_comb begin
		logic [PW-1:0]      w;
		logic [DIGIT_W-1:0] r;
		logic [DIGIT_W:0]   t;
		w = work_q;
		r = rem_q;
		t = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, w[PW-1]};
			w = {w[PW-2:0], 1'b0};
			if (t >= {1'b0, radix_q}) begin
				t    = t - {1'b0, radix_q};
				w[0] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		work_d = w;
		rem_d  = r;
	end

	assign status.step_last = (step_q == SCW'(STEPS - 1));
	assign status.div_end   = status.step_last &&
		((work_d == '0) || (count_q == CW'(DIGIT_SLOTS - 1)));
	assign status.idx_zero  = (idx_q == '0);
	assign status.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else if (cmd.load) begin
			step_q  <= '0;
			count_q <= '0;
		end else if (cmd.step) begin
			if (status.step_last) begin
				step_q  <= '0;
				count_q <= count_q + 1'b1;
				idx_q   <= count_q[AW-1:0];
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (cmd.emit) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= PW'(value);
			rem_q  <= '0;
		end else if (cmd.step) begin
			work_q <= work_d;
			rem_q  <= status.step_last ? '0 : rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && status.step_last) begin
			mem[count_q[AW-1:0]] <= rem_d;
		end
		if (cmd.rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digit_q <= rdata_q;
			last_q  <= status.idx_zero;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit      = digit_q;
	assign last_digit = last_q;

`ifndef SYNTHESIS
	a_digit_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (digit_q < radix_q))
		else $error("digit not below radix");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DIGIT_SLOTS))
		else $error("digit count beyond buffer");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");
`endif

endmodule

// File: rtl/core/radix_digit_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts each value to the configured radix (2..9) by repeated division and
// emits the digits most significant first, flagging the final digit.
// ----------------------------------------------------------------------------
// Sequence: the value is accepted, then the division passes run (8 quotient
//   bits per cycle in the shared divider), then each digit is read back from
//   the digit buffer by a read state, then a write state to the output register.
// Input: a new value is accepted only after the last digit of the previous
//   one has been emitted; output stall holds back the read-back.
// Reset: control state cleared, radix returns to 8; no clearing pass.
module radix_digit_converter_core
	import rdc_pkg::*;
#(
	parameter int VALUE_WIDTH = 31,
	parameter int DIGIT_SLOTS = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RADIX_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DIGIT_W-1:0]     digit,
	output logic                   last_digit
);

	rdc_cmd_t    cmd;
	rdc_status_t status;
	logic        busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (busy),
		.status   (status),
		.cmd      (cmd)
	);

	rdc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.digit      (digit),
		.last_digit (last_digit)
	);

endmodule
